// ----- rtl/bdb_pkg.sv -----
// Shared constants, codes and types for the B-spline de Boor evaluator.
// No dependencies; every other file but bdb_ram imports this package.
`default_nettype none
package bdb_pkg;

    localparam int MAX_POLES   = 64;
    localparam int MAX_DEGREE  = 7;
    localparam int FRAC_BITS   = 24;
    localparam int KNOT_DEPTH  = MAX_POLES + MAX_DEGREE + 1;
    localparam int WORK_DEPTH  = MAX_DEGREE + 1;
    localparam int T_W         = FRAC_BITS + 1;
    localparam int PIDX_W      = $clog2(MAX_POLES);
    localparam int KIDX_W      = $clog2(KNOT_DEPTH);
    localparam int COORD_W     = 32;
    localparam int POINT_W     = 3 * COORD_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int PADDR_W     = 4;

    localparam logic [T_W-1:0] ONE_Q = T_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_EVAL  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DEG_LOW  = 3'd1;
    localparam logic [2:0] ST_FEW      = 3'd2;
    localparam logic [2:0] ST_NODIV    = 3'd3;
    localparam logic [2:0] ST_BAD_TYPE = 3'd4;
    localparam logic [2:0] ST_UNBUILT  = 3'd5;

    localparam logic [1:0] KT_OPEN  = 2'd1;
    localparam logic [1:0] KT_PIECE = 2'd2;

    localparam logic [1:0] REG_DEGREE = 2'd0;
    localparam logic [1:0] REG_COUNT  = 2'd1;
    localparam logic [1:0] REG_KTYPE  = 2'd2;
    localparam logic [1:0] REG_MINDEG = 2'd3;

    typedef struct packed {
        logic [2:0] degree;
        logic [6:0] count;
        logic [1:0] ktype;
        logic [2:0] min_deg;
    } cfg_t;

    typedef struct packed {
        cmd_t                op;
        logic [PIDX_W-1:0]   pole_index;
        logic [POINT_W-1:0]  pole;
        logic [T_W-1:0]      t;
        logic                t_zero;
        logic                t_top;
    } item_t;

endpackage
`default_nettype wire

// ----- rtl/bdb_if.sv -----
// Valid/ready channel interfaces for command words and result words.
// Depends on bdb_pkg.
`default_nettype none
interface bdb_in_if import bdb_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [1:0]                  command;
    logic [5:0]                  pole_index;
    logic signed [COORD_W-1:0]   pole_x;
    logic signed [COORD_W-1:0]   pole_y;
    logic signed [COORD_W-1:0]   pole_z;
    logic [T_W-1:0]              param_t;

    modport source (output valid, command, pole_index, pole_x, pole_y, pole_z, param_t,
                    input ready);
    modport sink (input valid, command, pole_index, pole_x, pole_y, pole_z, param_t,
                  output ready);
endinterface

interface bdb_out_if import bdb_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [COORD_W-1:0]   out_x;
    logic signed [COORD_W-1:0]   out_y;
    logic signed [COORD_W-1:0]   out_z;
    logic [2:0]                  status;

    modport source (output valid, out_x, out_y, out_z, status, input ready);
    modport sink (input valid, out_x, out_y, out_z, status, output ready);
endinterface
`default_nettype wire

// ----- rtl/bspline_de_boor_evaluator.sv -----
// Top level of the B-spline de Boor evaluator: configuration registers,
// front end queue and execution back end. Depends on bdb_pkg, bdb_if and all bdb_ modules.
//
// Each command word gives exactly one result word. A build divides out each inner knot
// in the alpha divider and writes the end knots one at a time; piecewise first finds
// the segment count by repeated subtraction of the degree. An evaluate with t at 0
// or at or above 1.0 returns the first or the last pole. Inside the curve it runs
// the span search knot by knot, fetches the degree+1 poles one by one, then runs the
// degree*(degree+1)/2 recursion steps; each step is paced by the one-bit-per-cycle
// alpha divider and the shared multiplier that blends x, y and z one after another.
// Commands queue in a two-word buffer so the input side keeps accepting, until the
// buffer is full, while a result waits on the output.
`default_nettype none
module bspline_de_boor_evaluator import bdb_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    bdb_in_if.sink                  in_ch,
    bdb_out_if.source               out_ch,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    cfg_t  cfg_reg;
    logic  cfg_wr, q_valid, pop;
    item_t q_item;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.degree  <= 3'd3;
            cfg_reg.count   <= 7'd4;
            cfg_reg.ktype   <= KT_OPEN;
            cfg_reg.min_deg <= 3'd1;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_DEGREE: cfg_reg.degree  <= pwdata[2:0];
                REG_COUNT:  cfg_reg.count   <= pwdata[6:0];
                REG_KTYPE:  cfg_reg.ktype   <= pwdata[1:0];
                REG_MINDEG: cfg_reg.min_deg <= pwdata[2:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_DEGREE: prdata = {29'b0, cfg_reg.degree};
            REG_COUNT:  prdata = {25'b0, cfg_reg.count};
            REG_KTYPE:  prdata = {30'b0, cfg_reg.ktype};
            REG_MINDEG: prdata = {29'b0, cfg_reg.min_deg};
            default:    prdata = '0;
        endcase
    end

    bdb_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .pop(pop),
        .q_valid(q_valid), .q_item(q_item)
    );

    bdb_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .cfg_wr(cfg_wr),
        .q_valid(q_valid), .q_item(q_item), .pop(pop), .out_ch(out_ch)
    );
endmodule
`default_nettype wire

// ----- rtl/bdb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bdb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/bdb_front.sv -----
// Front end: accepts command words, classifies them and queues them.
// Depends on bdb_pkg and bdb_if.
`default_nettype none
module bdb_front import bdb_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    bdb_in_if.sink    in_ch,
    input  wire logic pop,
    output logic      q_valid,
    output item_t     q_item
);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    item_t                fifo_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]       cnt_reg;
    item_t                cls;
    logic                 push;

    always_comb
    begin
        cls.op         = cmd_t'(in_ch.command);
        cls.pole_index = in_ch.pole_index;
        cls.pole       = {in_ch.pole_x, in_ch.pole_y, in_ch.pole_z};
        cls.t          = in_ch.param_t;
        cls.t_zero     = (in_ch.param_t == '0);
        cls.t_top      = (in_ch.param_t >= ONE_Q);
    end

    assign in_ch.ready = (cnt_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != '0);
    assign q_item      = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                fifo_reg[wr_ptr_reg] <= cls;
                wr_ptr_reg           <= wr_ptr_reg + 1'b1;
            end
            if (pop && q_valid)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !(pop && q_valid))
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (!push && pop && q_valid)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/bdb_div.sv -----
// Rounded fractional divider: num * 2^FRAC_BITS / den, one quotient bit per cycle.
// Depends on bdb_pkg.
`default_nettype none
module bdb_div import bdb_pkg::*; (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [T_W-1:0] num,
    input  wire logic [T_W-1:0] den,
    output logic                done,
    output logic [T_W-1:0]      quo
);
    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;
    localparam int CNT_W = $clog2(FRAC_BITS);

    dstate_t                state_reg;
    logic [T_W-1:0]         rem_reg, den_reg;
    logic [FRAC_BITS-1:0]   q_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [T_W:0]           rem2, rnd_sum;

    assign rem2    = {rem_reg, 1'b0};
    assign rnd_sum = {1'b0, rem_reg} + {2'b0, den_reg[T_W-1:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done      <= 1'b0;
            quo       <= '0;
            rem_reg   <= '0;
            den_reg   <= '0;
            q_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        den_reg <= den;
                        rem_reg <= num;
                        q_reg   <= '0;
                        cnt_reg <= CNT_W'(FRAC_BITS - 1);
                        if (den == '0)
                        begin
                            quo  <= '0;
                            done <= 1'b1;
                        end
                        else if (num >= den)
                        begin
                            quo  <= ONE_Q;
                            done <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= D_RUN;
                        end
                    end
                end
                D_RUN:
                begin
                    if (rem2 >= {1'b0, den_reg})
                    begin
                        rem_reg <= T_W'(rem2 - {1'b0, den_reg});
                        q_reg   <= {q_reg[FRAC_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem2[T_W-1:0];
                        q_reg   <= {q_reg[FRAC_BITS-2:0], 1'b0};
                    end
                    if (cnt_reg == '0)
                    begin
                        state_reg <= D_FIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                D_FIN:
                begin
                    // Round half up: bump when the remainder reaches half the divisor.
                    quo       <= {1'b0, q_reg} + T_W'(rnd_sum >= {1'b0, den_reg});
                    done      <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/bdb_back.sv -----
// Back end: executes load, knot build and de Boor evaluation; holds the result word.
// Depends on bdb_pkg, bdb_if, bdb_ram and bdb_div.
`default_nettype none
module bdb_back import bdb_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  cfg_t      cfg,
    input  wire logic cfg_wr,
    input  wire logic q_valid,
    input  item_t     q_item,
    output logic      pop,
    bdb_out_if.source out_ch
);
    typedef enum logic [4:0] {
        S_IDLE, S_DONE, S_BCHK, S_OPEN, S_ODIV, S_PWDIV, S_PWG, S_PWW, S_PWWR,
        S_Z, S_O, S_EA, S_EB, S_SA, S_SB, S_SC, S_LA, S_LB,
        S_RA, S_RB, S_RC, S_RD, S_BM, S_BA, S_BW, S_FA, S_FB
    } state_t;

    state_t                   state_reg;
    item_t                    item_reg;
    logic                     kv_reg;
    logic [POINT_W-1:0]       res_reg;
    logic [2:0]               res_st_reg;
    logic                     out_valid_reg;
    logic [POINT_W-1:0]       out_pt_reg;
    logic [2:0]               out_st_reg;

    logic [6:0]               i_reg, j_reg, k_reg;
    logic [5:0]               rem_reg, segs_reg, g_reg;
    logic [2:0]               m_reg, cnt_reg, r_reg, jr_reg;
    logic [1:0]               c_reg;
    logic [T_W-1:0]           val_reg, prev_reg, klo_reg, alpha_reg;
    logic [POINT_W-1:0]       wj_reg, wjm_reg, new_reg;
    logic signed [58:0]       mul_reg;

    logic                     pole_we, knot_we, work_we, div_start, div_done;
    logic [PIDX_W-1:0]        pole_raddr;
    logic [POINT_W-1:0]       pole_rdata, work_rdata, work_wdata;
    logic [KIDX_W-1:0]        knot_waddr, knot_raddr;
    logic [T_W-1:0]           knot_wdata, knot_rdata, div_num, div_den, div_quo;
    logic [2:0]               work_waddr, work_raddr;

    logic [2:0]               d;
    logic [6:0]               p;
    logic [7:0]               pd, lo8, hi8, lda8;
    logic signed [31:0]       a_c, b_c, blend_c;
    logic signed [32:0]       diff;
    logic signed [59:0]       sum60;
    logic signed [35:0]       rsh;
    logic [6:0]               kclamp;

    assign d      = cfg.degree;
    assign p      = cfg.count;
    assign pd     = {1'b0, p} + {5'b0, d};
    assign lo8    = {1'b0, k_reg} + {5'b0, jr_reg} - {5'b0, d};
    assign hi8    = {1'b0, k_reg} + {5'b0, jr_reg} + 8'd1 - {5'b0, r_reg};
    assign lda8   = {1'b0, k_reg} + {5'b0, cnt_reg} - {5'b0, d};
    assign kclamp = (j_reg > p - 7'd1) ? p - 7'd1 : j_reg;

    function automatic logic signed [31:0] coord(input logic [POINT_W-1:0] pt,
                                                  input logic [1:0] c);
        case (c)
            2'd0:    coord = pt[95:64];
            2'd1:    coord = pt[63:32];
            default: coord = pt[31:0];
        endcase
    endfunction

    // Blend = a + alpha * (b - a), rounded half up and saturated.
    assign a_c   = coord(wjm_reg, c_reg);
    assign b_c   = coord(wj_reg, c_reg);
    assign diff  = {b_c[31], b_c} - {a_c[31], a_c};
    assign sum60 = {{4{a_c[31]}}, a_c, 24'b0} + {mul_reg[58], mul_reg}
                   + (60'sd1 <<< (FRAC_BITS - 1));
    assign rsh   = sum60[59:24];
    assign blend_c = (rsh > 36'sd2147483647) ? 32'sh7FFFFFFF :
                     (rsh < -36'sd2147483648) ? 32'sh80000000 : rsh[31:0];

    assign pop = (state_reg == S_IDLE);

    always_comb
    begin
        pole_we    = (state_reg == S_IDLE) && q_valid && (q_item.op == CMD_LOAD);
        pole_raddr = '0;
        knot_we    = 1'b0;
        knot_waddr = i_reg;
        knot_wdata = '0;
        knot_raddr = '0;
        work_we    = 1'b0;
        work_waddr = cnt_reg;
        work_wdata = pole_rdata;
        work_raddr = '0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        case (state_reg)
            S_EA:    pole_raddr = item_reg.t_zero ? '0 : PIDX_W'(p - 7'd1);
            S_LA:    pole_raddr = lda8[PIDX_W-1:0];
            S_LB:    work_we = 1'b1;
            S_OPEN:
            begin
                div_start = (i_reg < p);
                div_num   = T_W'(i_reg - {4'b0, d});
                div_den   = T_W'(p - {4'b0, d});
            end
            S_ODIV:
            begin
                knot_we    = div_done;
                knot_wdata = div_quo;
            end
            S_PWG:
            begin
                div_start = (g_reg < segs_reg);
                div_num   = T_W'(g_reg);
                div_den   = T_W'(segs_reg);
            end
            S_PWWR:
            begin
                knot_we    = 1'b1;
                knot_waddr = j_reg;
                knot_wdata = val_reg;
            end
            S_Z:     knot_we = 1'b1;
            S_O:
            begin
                knot_we    = 1'b1;
                knot_wdata = ONE_Q;
            end
            S_SA:    knot_raddr = KIDX_W'(d);
            S_SB:    knot_raddr = KIDX_W'(j_reg + 7'd1);
            S_SC:    knot_raddr = KIDX_W'(j_reg + 7'd2);
            S_RA:
            begin
                knot_raddr = lo8[KIDX_W-1:0];
                work_raddr = jr_reg;
            end
            S_RB:
            begin
                knot_raddr = hi8[KIDX_W-1:0];
                work_raddr = jr_reg - 3'd1;
            end
            S_RC:
            begin
                // The upper knot arrives from the knot RAM in this cycle.
                div_start = (knot_rdata > klo_reg);
                div_num   = (item_reg.t > klo_reg) ? item_reg.t - klo_reg : '0;
                div_den   = knot_rdata - klo_reg;
            end
            S_BW:
            begin
                work_we    = 1'b1;
                work_waddr = jr_reg;
                work_wdata = new_reg;
            end
            S_FA:    work_raddr = d;
            default: ;
        endcase
    end

    bdb_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POLES)) u_pole_ram (
        .clk(clk), .we(pole_we), .waddr(q_item.pole_index), .wdata(q_item.pole),
        .raddr(pole_raddr), .rdata(pole_rdata)
    );

    bdb_ram #(.WIDTH(T_W), .DEPTH(KNOT_DEPTH)) u_knot_ram (
        .clk(clk), .we(knot_we), .waddr(knot_waddr), .wdata(knot_wdata),
        .raddr(knot_raddr), .rdata(knot_rdata)
    );

    bdb_ram #(.WIDTH(POINT_W), .DEPTH(WORK_DEPTH)) u_work_ram (
        .clk(clk), .we(work_we), .waddr(work_waddr), .wdata(work_wdata),
        .raddr(work_raddr), .rdata(work_rdata)
    );

    bdb_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
        .done(div_done), .quo(div_quo)
    );

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.out_x  = out_pt_reg[95:64];
    assign out_ch.out_y  = out_pt_reg[63:32];
    assign out_ch.out_z  = out_pt_reg[31:0];
    assign out_ch.status = out_st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_pt_reg    <= '0;
            out_st_reg    <= ST_OK;
            item_reg      <= '0;
            res_reg       <= '0;
            res_st_reg    <= ST_OK;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            rem_reg       <= '0;
            segs_reg      <= '0;
            g_reg         <= '0;
            m_reg         <= '0;
            cnt_reg       <= '0;
            r_reg         <= '0;
            jr_reg        <= '0;
            c_reg         <= '0;
            val_reg       <= '0;
            prev_reg      <= '0;
            klo_reg       <= '0;
            alpha_reg     <= '0;
            wj_reg        <= '0;
            wjm_reg       <= '0;
            new_reg       <= '0;
            mul_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            // A register write or a new build drops the knot vector.
            if (cfg_wr || (state_reg == S_IDLE && q_valid && q_item.op == CMD_BUILD))
            begin
                kv_reg <= 1'b0;
            end
            else if (state_reg == S_O && {1'b0, i_reg} == pd)
            begin
                kv_reg <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        item_reg   <= q_item;
                        res_reg    <= '0;
                        res_st_reg <= ST_OK;
                        case (q_item.op)
                            CMD_BUILD:
                            begin
                                state_reg <= S_BCHK;
                            end
                            CMD_EVAL:
                            begin
                                if (!kv_reg)
                                begin
                                    res_st_reg <= ST_UNBUILT;
                                    state_reg  <= S_DONE;
                                end
                                else if (q_item.t_zero || q_item.t_top)
                                begin
                                    state_reg <= S_EA;
                                end
                                else
                                begin
                                    state_reg <= S_SA;
                                end
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_pt_reg    <= res_reg;
                        out_st_reg    <= res_st_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                S_BCHK:
                begin
                    i_reg <= {4'b0, d} + 7'd1;
                    j_reg <= {4'b0, d} + 7'd1;
                    if (d == 3'd0 || d < cfg.min_deg)
                    begin
                        res_st_reg <= ST_DEG_LOW;
                        state_reg  <= S_DONE;
                    end
                    else if (p < {4'b0, d} + 7'd1 || p > 7'(MAX_POLES))
                    begin
                        res_st_reg <= ST_FEW;
                        state_reg  <= S_DONE;
                    end
                    else if (cfg.ktype == KT_OPEN)
                    begin
                        state_reg <= S_OPEN;
                    end
                    else if (cfg.ktype == KT_PIECE)
                    begin
                        rem_reg   <= 6'(p - {4'b0, d} - 7'd1);
                        segs_reg  <= 6'd1;
                        state_reg <= S_PWDIV;
                    end
                    else
                    begin
                        res_st_reg <= ST_BAD_TYPE;
                        state_reg  <= S_DONE;
                    end
                end
                S_OPEN:
                begin
                    if (i_reg < p)
                    begin
                        state_reg <= S_ODIV;
                    end
                    else
                    begin
                        i_reg     <= '0;
                        state_reg <= S_Z;
                    end
                end
                S_ODIV:
                begin
                    if (div_done)
                    begin
                        i_reg     <= i_reg + 7'd1;
                        state_reg <= S_OPEN;
                    end
                end
                S_PWDIV:
                begin
                    // Repeated subtraction gives the segment count and the remainder.
                    if (rem_reg >= {3'b0, d})
                    begin
                        rem_reg  <= rem_reg - {3'b0, d};
                        segs_reg <= segs_reg + 6'd1;
                    end
                    else if (rem_reg != '0)
                    begin
                        res_st_reg <= ST_NODIV;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        g_reg     <= 6'd1;
                        state_reg <= S_PWG;
                    end
                end
                S_PWG:
                begin
                    if (g_reg < segs_reg)
                    begin
                        state_reg <= S_PWW;
                    end
                    else
                    begin
                        i_reg     <= '0;
                        state_reg <= S_Z;
                    end
                end
                S_PWW:
                begin
                    if (div_done)
                    begin
                        val_reg   <= div_quo;
                        m_reg     <= '0;
                        state_reg <= S_PWWR;
                    end
                end
                S_PWWR:
                begin
                    j_reg <= j_reg + 7'd1;
                    m_reg <= m_reg + 3'd1;
                    if (m_reg == d - 3'd1)
                    begin
                        g_reg     <= g_reg + 6'd1;
                        state_reg <= S_PWG;
                    end
                end
                S_Z:
                begin
                    if (i_reg == {4'b0, d})
                    begin
                        i_reg     <= p;
                        state_reg <= S_O;
                    end
                    else
                    begin
                        i_reg <= i_reg + 7'd1;
                    end
                end
                S_O:
                begin
                    if ({1'b0, i_reg} == pd)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        i_reg <= i_reg + 7'd1;
                    end
                end
                S_EA:    state_reg <= S_EB;
                S_EB:
                begin
                    res_reg   <= pole_rdata;
                    state_reg <= S_DONE;
                end
                S_SA:
                begin
                    j_reg     <= {4'b0, d};
                    state_reg <= S_SB;
                end
                S_SB:
                begin
                    prev_reg <= knot_rdata;
                    if ({1'b0, j_reg} + 8'd1 > pd)
                    begin
                        k_reg     <= p - 7'd1;
                        cnt_reg   <= '0;
                        state_reg <= S_LA;
                    end
                    else
                    begin
                        state_reg <= S_SC;
                    end
                end
                S_SC:
                begin
                    // Pair under test is knot j (held) and knot j+1 (just read).
                    cnt_reg <= '0;
                    if (prev_reg <= item_reg.t && item_reg.t < knot_rdata)
                    begin
                        k_reg     <= kclamp;
                        state_reg <= S_LA;
                    end
                    else
                    begin
                        prev_reg <= knot_rdata;
                        j_reg    <= j_reg + 7'd1;
                        if ({1'b0, j_reg} + 8'd2 > pd)
                        begin
                            k_reg     <= p - 7'd1;
                            state_reg <= S_LA;
                        end
                    end
                end
                S_LA:    state_reg <= S_LB;
                S_LB:
                begin
                    if (cnt_reg == d)
                    begin
                        r_reg     <= 3'd1;
                        jr_reg    <= d;
                        state_reg <= S_RA;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + 3'd1;
                        state_reg <= S_LA;
                    end
                end
                S_RA:    state_reg <= S_RB;
                S_RB:
                begin
                    klo_reg   <= knot_rdata;
                    wj_reg    <= work_rdata;
                    state_reg <= S_RC;
                end
                S_RC:
                begin
                    wjm_reg <= work_rdata;
                    c_reg   <= '0;
                    if (knot_rdata > klo_reg)
                    begin
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        alpha_reg <= '0;
                        state_reg <= S_BM;
                    end
                end
                S_RD:
                begin
                    if (div_done)
                    begin
                        alpha_reg <= div_quo;
                        state_reg <= S_BM;
                    end
                end
                S_BM:
                begin
                    mul_reg   <= $signed({1'b0, alpha_reg}) * diff;
                    state_reg <= S_BA;
                end
                S_BA:
                begin
                    case (c_reg)
                        2'd0:    new_reg[95:64] <= blend_c;
                        2'd1:    new_reg[63:32] <= blend_c;
                        default: new_reg[31:0]  <= blend_c;
                    endcase
                    if (c_reg == 2'd2)
                    begin
                        state_reg <= S_BW;
                    end
                    else
                    begin
                        c_reg     <= c_reg + 2'd1;
                        state_reg <= S_BM;
                    end
                end
                S_BW:
                begin
                    if (jr_reg == r_reg)
                    begin
                        if (r_reg == d)
                        begin
                            state_reg <= S_FA;
                        end
                        else
                        begin
                            r_reg     <= r_reg + 3'd1;
                            jr_reg    <= d;
                            state_reg <= S_RA;
                        end
                    end
                    else
                    begin
                        jr_reg    <= jr_reg - 3'd1;
                        state_reg <= S_RA;
                    end
                end
                S_FA:    state_reg <= S_FB;
                S_FB:
                begin
                    res_reg   <= work_rdata;
                    state_reg <= S_DONE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- sim/tb_bspline_de_boor_evaluator.sv -----
// Testbench for the B-spline de Boor evaluator: directed table, build errors, then random traffic.
// Depends on bdb_pkg, bdb_if and the evaluator RTL; predicts each result word locally.
`timescale 1ns / 1ps
module tb_bspline_de_boor_evaluator;
    import bdb_pkg::*;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    bdb_in_if in_ch ();
    bdb_out_if out_ch ();

    bspline_de_boor_evaluator u_dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [2:0] status;
    } point_t;

    typedef struct {
        cmd_t op;
        logic [5:0] index;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [T_W-1:0] t;
        logic known;
        logic [31:0] ex;
        logic [31:0] ey;
        logic [31:0] ez;
        logic [2:0] est;
    } row_t;

    // Local copy of the block's state.
    logic [2:0] m_degree;
    logic [6:0] m_count;
    logic [1:0] m_ktype;
    logic [2:0] m_mindeg;
    logic [31:0] m_pole [3][MAX_POLES];
    longint unsigned m_knot [KNOT_DEPTH];
    bit m_built;

    point_t expected_points[$];
    int errors;
    bit quiet;
    int out_stall_max;

    function automatic longint unsigned rdiv(longint unsigned num, longint unsigned den);
        return (num + den / 2) / den;
    endfunction

    function automatic logic [2:0] build_knot_vector();
        longint unsigned d;
        longint unsigned p;
        longint unsigned rest;
        longint unsigned segs;
        int idx;
        d = m_degree;
        p = m_count;
        m_built = 0;
        if (d == 0 || d < m_mindeg || d > MAX_DEGREE) return ST_DEG_LOW;
        if (p < d + 1 || p > MAX_POLES) return ST_FEW;
        if (m_ktype == KT_OPEN) begin
            for (longint unsigned i = d + 1; i < p; i++)
                m_knot[i] = rdiv((i - d) << FRAC_BITS, p - d);
        end
        else if (m_ktype == KT_PIECE) begin
            rest = p - d - 1;
            if (rest % d != 0) return ST_NODIV;
            segs = rest / d + 1;
            idx = int'(d + 1);
            for (longint unsigned g = 1; g < segs; g++)
                for (int m = 0; m < d; m++)
                    if (idx < KNOT_DEPTH) m_knot[idx++] = rdiv(g << FRAC_BITS, segs);
        end
        else begin
            return ST_BAD_TYPE;
        end
        for (int i = 0; i <= d; i++) m_knot[i] = 0;
        for (longint unsigned i = p; i <= p + d && i < KNOT_DEPTH; i++)
            m_knot[i] = longint'(1) << FRAC_BITS;
        m_built = 1;
        return ST_OK;
    endfunction

    function automatic longint mix(longint a, longint b, longint unsigned alpha);
        longint prod;
        longint r;
        prod = longint'((longint'(1) << FRAC_BITS) - alpha) * a + longint'(alpha) * b;
        r = (prod + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    function automatic point_t evaluate_point(longint unsigned t);
        point_t res;
        longint work [3][WORK_DEPTH];
        longint unsigned d;
        longint unsigned p;
        longint unsigned k;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned alpha;
        longint unsigned klo;
        longint unsigned khi;
        longint unsigned i;
        res = '{0, 0, 0, ST_OK};
        d = m_degree;
        p = m_count;
        if (!m_built) begin
            res.status = ST_UNBUILT;
            return res;
        end
        if (t == 0 || t >= (longint'(1) << FRAC_BITS)) begin
            i = (t == 0) ? 0 : p - 1;
            res.x = m_pole[0][i];
            res.y = m_pole[1][i];
            res.z = m_pole[2][i];
            return res;
        end
        k = p - 1;
        for (longint unsigned j = d; j + 1 < p + d + 1 && j + 1 < KNOT_DEPTH; j++)
            if (m_knot[j] <= t && t < m_knot[j + 1]) begin
                k = j;
                break;
            end
        if (k < d) k = d;
        if (k > p - 1) k = p - 1;
        for (int c = 0; c < 3; c++)
            for (longint unsigned j = 0; j <= d; j++)
                work[c][j] = longint'(signed'(m_pole[c][j + k - d]));
        for (longint unsigned r = 1; r <= d; r++)
            for (longint unsigned j = d; j >= r; j--) begin
                lo = j + k - d;
                hi = j + 1 + k - r;
                klo = m_knot[lo % KNOT_DEPTH];
                khi = m_knot[hi % KNOT_DEPTH];
                alpha = 0;
                if (khi > klo) begin
                    if (t > klo && t - klo >= khi - klo) alpha = longint'(1) << FRAC_BITS;
                    else if (t > klo) alpha = rdiv((t - klo) << FRAC_BITS, khi - klo);
                end
                for (int c = 0; c < 3; c++) work[c][j] = mix(work[c][j - 1], work[c][j], alpha);
            end
        res.x = work[0][d];
        res.y = work[1][d];
        res.z = work[2][d];
        return res;
    endfunction

    function automatic point_t predict_word(row_t w);
        point_t res;
        res = '{0, 0, 0, ST_OK};
        case (w.op)
            CMD_LOAD:
            begin
                m_pole[0][w.index] = w.px;
                m_pole[1][w.index] = w.py;
                m_pole[2][w.index] = w.pz;
            end
            CMD_BUILD: res.status = build_knot_vector();
            CMD_EVAL: res = evaluate_point(w.t);
            default: ;
        endcase
        return res;
    endfunction

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #400ms;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= PADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            REG_DEGREE: m_degree = val[2:0];
            REG_COUNT: m_count = val[6:0];
            REG_KTYPE: m_ktype = val[1:0];
            default: m_mindeg = val[2:0];
        endcase
        m_built = 0;
    endtask

    // Wait for the block to drain and every expected result word to arrive.
    task automatic drain();
        while (expected_points.size() != 0) @(posedge clk);
        repeat (3000) @(posedge clk);
    endtask

    task automatic send_word(row_t w);
        point_t p;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.command <= w.op;
        in_ch.pole_index <= w.index;
        in_ch.pole_x <= w.px;
        in_ch.pole_y <= w.py;
        in_ch.pole_z <= w.pz;
        in_ch.param_t <= w.t;
        do @(posedge clk); while (!in_ch.ready);
        p = predict_word(w);
        if (w.known) begin
            if (p.x !== w.ex) begin
                $error("table out_x expected %h got %h", w.ex, p.x);
                errors++;
            end
            if (p.y !== w.ey) begin
                $error("table out_y expected %h got %h", w.ey, p.y);
                errors++;
            end
            if (p.z !== w.ez) begin
                $error("table out_z expected %h got %h", w.ez, p.z);
                errors++;
            end
            if (p.status !== w.est) begin
                $error("table status expected %0d got %0d", w.est, p.status);
                errors++;
            end
        end
        expected_points.insert(expected_points.size(), p);
    endtask

    function automatic row_t mk(cmd_t op, logic [5:0] idx, logic [31:0] px, logic [31:0] py,
                                logic [31:0] pz, logic [T_W-1:0] t);
        row_t w;
        w = '{op, idx, px, py, pz, t, 0, 0, 0, 0, ST_OK};
        return w;
    endfunction

    function automatic row_t mkx(row_t w, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                 logic [2:0] st);
        w.known = 1;
        w.ex = x;
        w.ey = y;
        w.ez = z;
        w.est = st;
        return w;
    endfunction

    task automatic end_phase();
        in_ch.valid <= 0;
        drain();
    endtask

    // Random curve: load every pole in use, build, then send a batch of evaluates mixed with NOPs and reloads.
    task automatic random_curve(int evals);
        row_t w;
        int kind;
        for (int i = 0; i < m_count && i < MAX_POLES; i++)
        begin
            kind = $urandom_range(0, 9);
            w = mk(CMD_LOAD, 6'(i), $urandom, $urandom, $urandom, 0);
            if (kind < 6) begin
                w.px = $signed(w.px) >>> 8;
                w.py = $signed(w.py) >>> 8;
                w.pz = $signed(w.pz) >>> 8;
            end
            send_word(w);
        end
        send_word(mk(CMD_BUILD, 0, 0, 0, 0, 0));
        for (int i = 0; i < evals; i++)
        begin
            kind = $urandom_range(0, 19);
            w = mk(CMD_EVAL, 0, 0, 0, 0, T_W'($urandom_range(1, ONE_Q - 1)));
            if (kind == 0) w.t = 0;
            else if (kind == 1) w.t = T_W'($urandom_range(ONE_Q, 2 ** T_W - 1));
            else if (kind == 2) w.t = ONE_Q;
            else if (kind == 3) w.op = CMD_NOP;
            else if (kind == 4) begin
                w = mk(CMD_LOAD, 6'($urandom_range(0, m_count - 1)), $urandom, $urandom,
                       $urandom, 0);
            end
            send_word(w);
        end
    endtask

    initial
    begin
        row_t tbl[$];
        int deg;
        int cnt;
        errors = 0;
        quiet = 0;
        out_stall_max = 19;
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 0;
        in_ch.command = CMD_NOP;
        in_ch.pole_index = '0;
        in_ch.pole_x = '0;
        in_ch.pole_y = '0;
        in_ch.pole_z = '0;
        in_ch.param_t = '0;
        m_degree = 3;
        m_count = 4;
        m_ktype = KT_OPEN;
        m_mindeg = 1;
        m_built = 0;
        for (int i = 0; i < MAX_POLES; i++)
        begin
            for (int c = 0; c < 3; c++) m_pole[c][i] = '0;
        end
        foreach (m_knot[i]) m_knot[i] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed table under the reset configuration.
        tbl.insert(tbl.size(), mkx(mk(CMD_EVAL, 0, 0, 0, 0, ONE_Q >> 1), 0, 0, 0, ST_UNBUILT));
        tbl.insert(tbl.size(), mkx(mk(CMD_LOAD, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 0),
                                   0, 0, 0, ST_OK));
        tbl.insert(tbl.size(), mk(CMD_LOAD, 1, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0));
        tbl.insert(tbl.size(), mk(CMD_LOAD, 2, 32'h0001_0000, 32'hffff_0000, 32'h5555_aaaa, 0));
        tbl.insert(tbl.size(), mk(CMD_LOAD, 3, 32'h7fff_ffff, 32'h7fff_ffff, 32'haaaa_5555, 0));
        tbl.insert(tbl.size(), mk(CMD_LOAD, 63, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0));
        tbl.insert(tbl.size(), mkx(mk(CMD_BUILD, 0, 0, 0, 0, 0), 0, 0, 0, ST_OK));
        tbl.insert(tbl.size(), mkx(mk(CMD_EVAL, 0, 0, 0, 0, 0), 32'h8000_0000, 32'h7fff_ffff,
                                   0, ST_OK));
        tbl.insert(tbl.size(), mkx(mk(CMD_EVAL, 0, 0, 0, 0, ONE_Q), 32'h7fff_ffff,
                                   32'h7fff_ffff, 32'haaaa_5555, ST_OK));
        tbl.insert(tbl.size(), mkx(mk(CMD_EVAL, 0, 0, 0, 0, 25'h1ff_ffff), 32'h7fff_ffff,
                                   32'h7fff_ffff, 32'haaaa_5555, ST_OK));
        tbl.insert(tbl.size(), mk(CMD_EVAL, 0, 0, 0, 0, 1));
        tbl.insert(tbl.size(), mk(CMD_EVAL, 0, 0, 0, 0, ONE_Q >> 1));
        tbl.insert(tbl.size(), mk(CMD_EVAL, 0, 0, 0, 0, ONE_Q - 1));
        tbl.insert(tbl.size(), mkx(mk(CMD_NOP, 6'h3f, 32'hffff_ffff, 32'hffff_ffff,
                                      32'hffff_ffff, 25'h1ff_ffff), 0, 0, 0, ST_OK));
        foreach (tbl[i]) send_word(tbl[i]);
        end_phase();

        // Build errors, each status code at least once, and an evaluate on an unbuilt curve.
        write_reg(REG_MINDEG, 4);
        send_word(mkx(mk(CMD_BUILD, 0, 0, 0, 0, 0), 0, 0, 0, ST_DEG_LOW));
        send_word(mkx(mk(CMD_EVAL, 0, 0, 0, 0, 100), 0, 0, 0, ST_UNBUILT));
        end_phase();
        write_reg(REG_MINDEG, 1);
        write_reg(REG_DEGREE, 0);
        send_word(mkx(mk(CMD_BUILD, 0, 0, 0, 0, 0), 0, 0, 0, ST_DEG_LOW));
        end_phase();
        write_reg(REG_DEGREE, 3);
        write_reg(REG_COUNT, 3);
        send_word(mkx(mk(CMD_BUILD, 0, 0, 0, 0, 0), 0, 0, 0, ST_FEW));
        end_phase();
        write_reg(REG_COUNT, 127);
        send_word(mkx(mk(CMD_BUILD, 0, 0, 0, 0, 0), 0, 0, 0, ST_FEW));
        end_phase();
        write_reg(REG_COUNT, 5);
        write_reg(REG_KTYPE, 32'(KT_PIECE));
        send_word(mkx(mk(CMD_BUILD, 0, 0, 0, 0, 0), 0, 0, 0, ST_NODIV));
        end_phase();
        write_reg(REG_KTYPE, 0);
        send_word(mkx(mk(CMD_BUILD, 0, 0, 0, 0, 0), 0, 0, 0, ST_BAD_TYPE));
        end_phase();
        write_reg(REG_KTYPE, 3);
        send_word(mkx(mk(CMD_BUILD, 0, 0, 0, 0, 0), 0, 0, 0, ST_BAD_TYPE));
        end_phase();

        // Random phases over many settings, the largest ones included.
        for (int ph = 0; ph < 24; ph++)
        begin
            if (ph == 0) begin
                deg = 7;
                cnt = 64;
            end
            else if (ph == 1) begin
                deg = 1;
                cnt = 2;
            end
            else if (ph == 2) begin
                deg = 7;
                cnt = 8;
            end
            else begin
                deg = $urandom_range(1, 7);
                cnt = $urandom_range(deg + 1, deg + 12);
            end
            if (ph >= 20) quiet = 1;
            if (ph >= 20) out_stall_max = 0;
            write_reg(REG_DEGREE, deg);
            write_reg(REG_COUNT, cnt);
            if ($urandom_range(0, 1) && ((cnt - deg - 1) % deg == 0))
                write_reg(REG_KTYPE, 32'(KT_PIECE));
            else
                write_reg(REG_KTYPE, 32'(KT_OPEN));
            write_reg(REG_MINDEG, $urandom_range(1, deg));
            random_curve(ph < 3 ? 8 : 24);
            end_phase();
        end

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stalls and the field-by-field comparison.
    initial
    begin
        point_t e;
        out_ch.ready = 0;
        @(posedge rst_n);
        forever
        begin
            if (out_stall_max != 0 && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            out_ch.ready <= 1;
            @(posedge clk);
            if (out_ch.valid && out_ch.ready) begin
                if (expected_points.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else begin
                    e = expected_points.pop_front();
                    if (out_ch.out_x !== e.x) begin
                        $error("out_x expected %h got %h", e.x, out_ch.out_x);
                        errors++;
                    end
                    if (out_ch.out_y !== e.y) begin
                        $error("out_y expected %h got %h", e.y, out_ch.out_y);
                        errors++;
                    end
                    if (out_ch.out_z !== e.z) begin
                        $error("out_z expected %h got %h", e.z, out_ch.out_z);
                        errors++;
                    end
                    if (out_ch.status !== e.status) begin
                        $error("status expected %0d got %0d", e.status, out_ch.status);
                        errors++;
                    end
                end
            end
        end
    end
endmodule
